// File: src/fbpa_pkg.sv
// Package for the fixed block pool allocator: field widths, status codes,
// register map and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fbpa_pkg;

    // Fixed field widths of the channels and the register
    localparam int IDX_W   = 10;
    localparam int CNT_W   = 11;
    localparam int DATA_W  = 32;
    localparam int PADDR_W = 3;

    // Pool size limits
    localparam int MAX_BLOCKS_DEFAULT = 1024;
    localparam logic [CNT_W-1:0] POOL_RESET = 11'd1024;

    // Register index decoded from the word address bit
    localparam logic REG_POOL_BLOCKS = 1'b0;

    // Operation codes on the input word
    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_NULL      = 2'd2,
        ST_OVERFLOW  = 2'd3
    } t_status;

    // Controller to datapath
    typedef struct packed {
        logic accept_alloc;
        logic accept_release;
        logic finish_alloc;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic in_is_alloc;
    } t_stat;

endpackage

`default_nettype wire

// File: src/fbpa_if.sv
// Valid/ready channel interfaces for the allocator request and result words.
// Depends on fbpa_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface fbpa_in_if;
    logic                        valid;
    logic                        ready;
    logic                        op;
    logic [fbpa_pkg::IDX_W-1:0]  release_index;
    logic                        release_is_null;

    modport source (output valid, output op, output release_index,
                    output release_is_null, input ready);
    modport sink   (input valid, input op, input release_index,
                    input release_is_null, output ready);
endinterface

interface fbpa_out_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  status;
    logic [fbpa_pkg::IDX_W-1:0]  granted_index;
    logic [fbpa_pkg::CNT_W-1:0]  free_blocks;

    modport source (output valid, output status, output granted_index,
                    output free_blocks, input ready);
    modport sink   (input valid, input status, input granted_index,
                    input free_blocks, output ready);
endinterface

`default_nettype wire

// File: src/fixed_block_pool_allocator.sv
// Top level of the fixed block pool allocator: channels, APB register port,
// controller and datapath. Depends on fbpa_pkg, fbpa_if, fbpa_ctrl, fbpa_datapath.
//
// Usage:
//   i_in carries request words: op (allocate or release), release_index and
//   release_is_null. o_out returns one result word per request: status,
//   granted_index and free_blocks. Both are valid/ready channels.
//   The APB port holds pool_blocks at byte address 0; writing it restarts
//   the pool (head 0, nothing allocated). Write only while the block is idle.
// Sequencing:
//   A release is answered in the cycle after it is accepted. An allocate
//   waits in S_ALLOC for the head's link, which gives the next head, from a
//   synchronous memory read and for a free result slot. One request is in
//   work at a time: one per cycle for releases while results are taken.
// Reset:
//   Synchronous, active low. The pool restarts with pool_blocks = 1024;
//   the link memory is not cleared and is filled lazily by allocates.
// Stall:
//   A result holds on o_out until taken; a new request is accepted only
//   when the result slot is empty or being taken in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module fixed_block_pool_allocator #(
    parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEFAULT
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    fbpa_in_if.sink                            i_in,
    fbpa_out_if.source                         o_out,
    input  wire logic                          i_psel,
    input  wire logic                          i_penable,
    input  wire logic                          i_pwrite,
    input  wire logic [fbpa_pkg::PADDR_W-1:0]  i_paddr,
    input  wire logic [fbpa_pkg::DATA_W-1:0]   i_pwdata,
    output logic [fbpa_pkg::DATA_W-1:0]        o_prdata,
    output logic                               o_pready
);

    fbpa_pkg::t_cmd  cmd;
    fbpa_pkg::t_stat stat;
    logic            cfg_we;
    logic [fbpa_pkg::CNT_W-1:0] pool_blocks;
    logic            reg_hit;

    // Decode the single register
    assign reg_hit  = (i_paddr[fbpa_pkg::PADDR_W-1] == fbpa_pkg::REG_POOL_BLOCKS);
    assign cfg_we   = i_psel && i_penable && i_pwrite && reg_hit;
    assign o_pready = 1'b1;
    assign o_prdata = reg_hit ? fbpa_pkg::DATA_W'(pool_blocks) : '0;

    fbpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    fbpa_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_op              (i_in.op),
        .i_release_index   (i_in.release_index),
        .i_release_is_null (i_in.release_is_null),
        .i_cfg_we          (cfg_we),
        .i_cfg_data        (i_pwdata[fbpa_pkg::CNT_W-1:0]),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .o_pool_blocks     (pool_blocks),
        .o_status          (o_out.status),
        .o_granted_index   (o_out.granted_index),
        .o_free_blocks     (o_out.free_blocks)
    );

endmodule

`default_nettype wire

// File: src/fbpa_ctrl.sv
// Controller of the allocator: sequencing state machine and result valid flag.
// Depends on fbpa_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module fbpa_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    input  wire fbpa_pkg::t_stat i_stat,
    output fbpa_pkg::t_cmd       o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_ALLOC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;
    logic   accept;
    logic   out_load;

    // Result slot is free when empty or being taken this cycle
    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;
    assign accept     = i_in_valid && o_in_ready;

    // Sequence: release finishes on accept, allocate waits in S_ALLOC for the link read
    always_comb begin
        n_state  = r_state;
        o_cmd    = '0;
        out_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_stat.in_is_alloc) begin
                        o_cmd.accept_alloc = 1'b1;
                        n_state            = S_ALLOC;
                    end else begin
                        o_cmd.accept_release = 1'b1;
                        out_load             = 1'b1;
                    end
                end
            end
            S_ALLOC: begin
                if (out_free) begin
                    o_cmd.finish_alloc = 1'b1;
                    out_load           = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold the result valid until the receiver takes the word
    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// File: src/fbpa_datapath.sv
// Datapath of the allocator: link memory, head/count registers, pool size
// register and result word registers. Depends on fbpa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fbpa_datapath #(
    parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEFAULT
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_op,
    input  wire logic [fbpa_pkg::IDX_W-1:0] i_release_index,
    input  wire logic                       i_release_is_null,
    input  wire logic                       i_cfg_we,
    input  wire logic [fbpa_pkg::CNT_W-1:0] i_cfg_data,
    input  wire fbpa_pkg::t_cmd             i_cmd,
    output fbpa_pkg::t_stat                 o_stat,
    output logic [fbpa_pkg::CNT_W-1:0]      o_pool_blocks,
    output logic [1:0]                      o_status,
    output logic [fbpa_pkg::IDX_W-1:0]      o_granted_index,
    output logic [fbpa_pkg::CNT_W-1:0]      o_free_blocks
);

    localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = fbpa_pkg::CNT_W;

    // Link memory, no reset: entries are written before they are read
    logic [CW-1:0] mem [MAX_BLOCKS];

    logic [CW-1:0] r_pool, n_pool;
    logic [AW-1:0] r_head, n_head;
    logic          r_head_present, n_head_present;
    logic [CW-1:0] r_alloc_cnt, n_alloc_cnt;
    logic [CW-1:0] r_touched, n_touched;
    logic [CW-1:0] r_rdata;
    logic          r_byp, n_byp;
    logic [CW-1:0] r_byp_data, n_byp_data;
    logic [1:0]    r_status, n_status;
    logic [fbpa_pkg::IDX_W-1:0] r_granted, n_granted;
    logic [CW-1:0] r_free, n_free;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [CW-1:0] mem_wdata;
    logic          mem_re;

    logic [CW-1:0] pool_n;
    logic [CW-1:0] link_now;
    logic [AW-1:0] link_head;
    logic [CW-1:0] cnt_inc;
    logic          lazy_fill;

    // Clamp the pool size to 1..MAX_BLOCKS for use; the register keeps the written value
    always_comb begin
        pool_n = r_pool;
        if (r_pool == '0) begin
            pool_n = CW'(1);
        end else if (int'(r_pool) > MAX_BLOCKS) begin
            pool_n = CW'(MAX_BLOCKS);
        end
    end

    assign o_stat.in_is_alloc = (i_op == fbpa_pkg::OP_ALLOC);
    assign lazy_fill = (r_touched < pool_n);
    assign cnt_inc   = r_alloc_cnt + CW'(1);

    // Link read back, with the same-cycle lazy write forwarded
    assign link_now = r_byp ? r_byp_data : r_rdata;

    // Reduce a link modulo the memory depth; links never reach twice the depth
    always_comb begin
        if (int'(link_now) >= MAX_BLOCKS) begin
            link_head = AW'(int'(link_now) - MAX_BLOCKS);
        end else begin
            link_head = AW'(link_now);
        end
    end

    // Next-state logic for list, counters and the result word
    always_comb begin
        n_pool         = r_pool;
        n_head         = r_head;
        n_head_present = r_head_present;
        n_alloc_cnt    = r_alloc_cnt;
        n_touched      = r_touched;
        n_byp          = r_byp;
        n_byp_data     = r_byp_data;
        n_status       = r_status;
        n_granted      = r_granted;
        n_free         = r_free;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_re         = 1'b0;

        if (i_cfg_we) begin
            // Restart the pool; links stay
            n_pool         = i_cfg_data;
            n_head         = '0;
            n_head_present = 1'b1;
            n_alloc_cnt    = '0;
            n_touched      = '0;
        end else if (i_cmd.accept_alloc) begin
            // Fill the next untouched link and fetch the head's link
            mem_re = 1'b1;
            n_byp  = 1'b0;
            if (lazy_fill) begin
                mem_we     = 1'b1;
                mem_waddr  = AW'(r_touched);
                mem_wdata  = r_touched + CW'(1);
                n_touched  = r_touched + CW'(1);
                n_byp      = (AW'(r_touched) == r_head);
                n_byp_data = r_touched + CW'(1);
            end
        end else if (i_cmd.finish_alloc) begin
            // Hand out the head and advance it, or report the pool exhausted
            if (r_alloc_cnt < pool_n) begin
                n_status    = fbpa_pkg::ST_OK;
                n_granted   = fbpa_pkg::IDX_W'(r_head);
                n_alloc_cnt = cnt_inc;
                if (cnt_inc < pool_n) begin
                    n_head         = link_head;
                    n_head_present = 1'b1;
                end else begin
                    n_head_present = 1'b0;
                end
                n_free = pool_n - cnt_inc;
            end else begin
                n_status  = fbpa_pkg::ST_EXHAUSTED;
                n_granted = '0;
                n_free    = pool_n - r_alloc_cnt;
            end
        end else if (i_cmd.accept_release) begin
            n_granted = '0;
            n_free    = pool_n - r_alloc_cnt;
            if (i_release_is_null || (CW'(i_release_index) >= pool_n)) begin
                n_status = fbpa_pkg::ST_NULL;
            end else if (r_alloc_cnt == '0) begin
                n_status = fbpa_pkg::ST_OVERFLOW;
            end else begin
                // Push the block onto the head
                n_status       = fbpa_pkg::ST_OK;
                mem_we         = 1'b1;
                mem_waddr      = AW'(i_release_index);
                mem_wdata      = r_head_present ? CW'(r_head) : pool_n;
                n_head         = AW'(i_release_index);
                n_head_present = 1'b1;
                n_alloc_cnt    = r_alloc_cnt - CW'(1);
                n_free         = pool_n - (r_alloc_cnt - CW'(1));
            end
        end
    end

    // Link memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[r_head];
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool         <= fbpa_pkg::POOL_RESET;
            r_head         <= '0;
            r_head_present <= 1'b1;
            r_alloc_cnt    <= '0;
            r_touched      <= '0;
            r_byp          <= 1'b0;
        end else begin
            r_pool         <= n_pool;
            r_head         <= n_head;
            r_head_present <= n_head_present;
            r_alloc_cnt    <= n_alloc_cnt;
            r_touched      <= n_touched;
            r_byp          <= n_byp;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_byp_data <= n_byp_data;
        r_status   <= n_status;
        r_granted  <= n_granted;
        r_free     <= n_free;
    end

    assign o_pool_blocks   = r_pool;
    assign o_status        = r_status;
    assign o_granted_index = r_granted;
    assign o_free_blocks   = r_free;

endmodule

`default_nettype wire

// File: src/fbpa_checker.sv
// Port-level checker for the allocator, bound to the top level.
// Depends on fbpa_pkg for status codes and widths.
`timescale 1ns / 1ps
`default_nettype none

module fbpa_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_in_ready,
    input wire logic                       i_out_valid,
    input wire logic                       i_out_ready,
    input wire logic [1:0]                 i_status,
    input wire logic [fbpa_pkg::IDX_W-1:0] i_granted_index,
    input wire logic [fbpa_pkg::CNT_W-1:0] i_free_blocks
);

    // A stalled result word stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    // A stalled result word keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_status) && $stable(i_granted_index) && $stable(i_free_blocks))
        else $error("result word changed while stalled");

    // An exhausted pool reports no free block
    a_exhausted_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == fbpa_pkg::ST_EXHAUSTED) |-> (i_free_blocks == '0))
        else $error("exhausted status with free blocks left");

    // No request is taken while a stalled result occupies the slot
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("request accepted over a stalled result");

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_status        (o_out.status),
    .i_granted_index (o_out.granted_index),
    .i_free_blocks   (o_out.free_blocks)
);

`default_nettype wire
